[src/rtr_pkg.sv]
// ----------------------------------------------------------------------------
// rtr_pkg: shared types and constants for the rounded timescale rescaler
// Register indexes, widths and the per-stage divider record.
// ----------------------------------------------------------------------------
package rtr_pkg;

	localparam int TimeW  = 64;
	localparam int ScaleW = 32;
	localparam int ProdW  = TimeW + ScaleW;	// 96-bit numerator
	localparam int IdxW   = 1;
	localparam int DivBitsPerStage = 4;
	localparam int DivStages = ProdW / DivBitsPerStage;	// 24

	typedef enum logic [IdxW-1:0] {
		REG_TARGET_SCALE = 1'b0,
		REG_SOURCE_SCALE = 1'b1
	} reg_idx_t;

	// one divider stage: remainder, partially built quotient, divisor
	typedef struct packed {
		logic              vld;
		logic [ScaleW:0]   rem;	// one bit over the divisor
		logic [ProdW-1:0]  num;	// numerator bits shift out, quotient bits in
		logic [ScaleW-1:0] div;
		logic              err;
	} div_stage_t;

endpackage

[src/rounded_timescale_rescale.sv]
// ----------------------------------------------------------------------------
// rounded_timescale_rescale: 64-bit timestamp rescaler with round-half-up
// scaled = (time * target + source/2) / source, modulo 2^64.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats arrive on in_valid/in_ready with time_value; results leave on
//   out_valid/out_ready as scaled_value and divide_error. Registers are set on
//   cfg_valid/cfg_ready (index 0 target_scale, index 1 source_scale, both reset
//   to 1; other indexes are ignored). cfg_ready is always high.
//   Throughput is one beat per cycle while the output is not stalled. There
//   are three stages for the 64x32 multiply (two 32x32 partial products,
//   their sum, then the add with the rounding term) and 24 divider stages
//   of four quotient bits each.
//   A source_scale of zero gives 0 with divide_error set.
//   The whole pipeline advances as one; when the receiver stalls with the
//   output full, every stage holds and in_ready drops. Reset empties it.
// ----------------------------------------------------------------------------
module rounded_timescale_rescale (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [rtr_pkg::IdxW-1:0]   cfg_index,
	input  logic [rtr_pkg::ScaleW-1:0] cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [rtr_pkg::TimeW-1:0]  time_value,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [rtr_pkg::TimeW-1:0]  scaled_value,
	output logic                       divide_error
);
	import rtr_pkg::*;

	logic [ScaleW-1:0] target_q, source_q;
	logic en;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= ScaleW'(1);
			source_q <= ScaleW'(1);
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_TARGET_SCALE: target_q <= cfg_data;
				REG_SOURCE_SCALE: source_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline advances when the output slot is empty or being taken
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// stage 1: partial products
	logic              vld_s1, vld_s2, vld_s3;
	logic [63:0]       plo_s1, phi_s1;
	logic [ScaleW-1:0] div_s1, div_s2, div_s3;
	logic [ProdW-1:0]  prod_s2, num_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			plo_s1  <= 64'(time_value[31:0])  * 64'(target_q);
			phi_s1  <= 64'(time_value[63:32]) * 64'(target_q);
			div_s1  <= source_q;
			prod_s2 <= {32'd0, plo_s1} + {phi_s1, 32'd0};
			div_s2  <= div_s1;
			num_s3  <= prod_s2 + ProdW'(div_s2 >> 1);
			div_s3  <= div_s2;
		end
	end

	div_stage_t d_in, d_out;
	always_comb begin
		d_in.vld = vld_s3;
		d_in.rem = '0;
		d_in.num = num_s3;
		d_in.div = div_s3;
		d_in.err = (div_s3 == '0);
	end

	rtr_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_st  (d_in),
		.out_st (d_out)
	);

	assign out_valid    = d_out.vld;
	assign divide_error = d_out.err;
	assign scaled_value = d_out.err ? '0 : d_out.num[TimeW-1:0];

endmodule

[src/rtr_divider.sv]
// ----------------------------------------------------------------------------
// rtr_divider: pipelined restoring divider, 96-bit numerator by 32-bit divisor
// Four quotient bits per stage, one beat a cycle, global enable for stalls.
// ----------------------------------------------------------------------------
module rtr_divider (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  rtr_pkg::div_stage_t       in_st,
	output rtr_pkg::div_stage_t       out_st
);
	import rtr_pkg::*;

	div_stage_t stg_q [DivStages+1];
	div_stage_t nxt [DivStages];

	assign stg_q[0] = in_st;

	always_comb begin
		for (int s = 0; s < DivStages; s++) begin
			logic [ScaleW:0]  r;
			logic [ProdW-1:0] n;
			r = stg_q[s].rem;
			n = stg_q[s].num;
			for (int b = 0; b < DivBitsPerStage; b++) begin
				logic [ScaleW+1:0] t;
				t = {r, n[ProdW-1]};
				n = {n[ProdW-2:0], 1'b0};
				if (t >= {2'b00, stg_q[s].div}) begin
					t = t - {2'b00, stg_q[s].div};
					n[0] = 1'b1;
				end
				r = t[ScaleW:0];
			end
			nxt[s] = stg_q[s];
			nxt[s].rem = r;
			nxt[s].num = n;
		end
	end

	for (genvar g = 0; g < DivStages; g++) begin : g_stage
		div_stage_t st_s1;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				st_s1 <= '0;
			end else if (en) begin
				st_s1 <= nxt[g];
			end
		end
		assign stg_q[g+1] = st_s1;
	end

	assign out_st = stg_q[DivStages];

endmodule

[src/rtr_checker.sv]
// ----------------------------------------------------------------------------
// rtr_checker: port-level checks for the rescaler
// Output stability under stall, error result shape, input readiness with an empty output, configuration readiness.
// ----------------------------------------------------------------------------
module rtr_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       cfg_ready,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [rtr_pkg::TimeW-1:0]  scaled_value,
	input logic                       divide_error
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(scaled_value))
		else $error("result changed under stall");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && divide_error |-> scaled_value == '0)
		else $error("error beat with nonzero value");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");

	a_cfg: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("configuration port not ready");
endmodule

bind rounded_timescale_rescale rtr_checker u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.cfg_ready    (cfg_ready),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.scaled_value (scaled_value),
	.divide_error (divide_error)
);
